>>> rtl/core/ordered_dirty_list_with_batch_cursor_defines.svh
// Assertion helpers shared by the list engine.
`ifndef ORDERED_DIRTY_LIST_WITH_BATCH_CURSOR_DEFINES_SVH
`define ORDERED_DIRTY_LIST_WITH_BATCH_CURSOR_DEFINES_SVH

// Same-cycle implication.
`define ODL_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ODL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/odl_pkg.sv
`timescale 1ns / 1ps
package odl_pkg;

   localparam int SLOTS_DEF     = 1024;
   localparam int MAX_BATCH_DEF = 64;
   // wide enough for any slot or marker at the largest slot count
   localparam int WIDE_W        = 17;

   localparam logic [6:0]  BATCH_SIZE_RST = 7'd16;
   localparam logic [20:0] MAX_BATCH_RST  = 21'd1024;

   typedef enum logic [1:0] {
      FN_INSERT = 2'd0,
      FN_REMOVE = 2'd1,
      FN_ADJUST = 2'd2,
      FN_BATCH  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_LISTED     = 2'd1,
      ST_NOT_LISTED = 2'd2,
      ST_ORDER      = 2'd3
   } status_type;

   typedef enum logic {
      CSR_BATCH_SIZE = 1'b0,
      CSR_MAX_BATCH  = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DECIDE,
      S_UNLINK,
      S_SELF,
      S_LINK,
      S_COUNT,
      S_EMIT,
      S_RESP
   } state_type;

   // one result beat handed from the engine to the output register
   typedef struct packed {
      logic [9:0]  slot_out;
      logic        slot_valid;
      logic        last;
      logic [6:0]  batch_count;
      logic [1:0]  status;
      logic [10:0] list_count;
   } beat_type;

endpackage

>>> rtl/core/ordered_dirty_list_with_batch_cursor.sv
`timescale 1ns / 1ps
// Throughput: one item at a time. Link write ports set updates; the link read sets the walk.
// Reset: synchronous, active high; a clearing pass marks every slot unlisted, and no item is
// accepted until it ends. Registers reset to 16 and 1024.
module ordered_dirty_list_with_batch_cursor
   import odl_pkg::*;
#(
   parameter int SLOTS     = SLOTS_DEF,
   parameter int MAX_BATCH = MAX_BATCH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [20:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [9:0]  req_slot,
   input  logic [63:0] req_log_pos,
   input  logic [63:0] req_fake_pos,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [9:0]  rsp_slot_out,
   output logic        rsp_slot_valid,
   output logic        rsp_last,
   output logic [6:0]  rsp_batch_count,
   output logic [1:0]  rsp_status,
   output logic [10:0] rsp_list_count
);

   logic [6:0]  batch_size_ff;
   logic [20:0] max_batch_ff;
   logic        rsp_valid_ff;
   beat_type    beat_ff, beat;
   logic        beat_load, out_free;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         batch_size_ff <= BATCH_SIZE_RST;
         max_batch_ff  <= MAX_BATCH_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BATCH_SIZE: batch_size_ff <= csr_wdata[6:0];
            CSR_MAX_BATCH:  max_batch_ff  <= csr_wdata;
            default:        max_batch_ff  <= max_batch_ff;
         endcase
      end
   end

   odl_engine #(.SLOTS(SLOTS), .MAX_BATCH(MAX_BATCH)) u_engine (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_func(req_func), .req_slot(req_slot),
      .req_log_pos(req_log_pos), .req_fake_pos(req_fake_pos),
      .batch_size(batch_size_ff), .max_batch(max_batch_ff),
      .out_free(out_free), .beat_load(beat_load), .beat(beat)
   );

   // output register
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (beat_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (beat_load) begin
         beat_ff <= beat;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_slot_out    = beat_ff.slot_out;
   assign rsp_slot_valid  = beat_ff.slot_valid;
   assign rsp_last        = beat_ff.last;
   assign rsp_batch_count = beat_ff.batch_count;
   assign rsp_status      = beat_ff.status;
   assign rsp_list_count  = beat_ff.list_count;

endmodule

>>> rtl/core/odl_ram.sv
`timescale 1ns / 1ps
module odl_ram
   import odl_pkg::*;
#(
   parameter int DEPTH = SLOTS_DEF,
   parameter int WIDTH = 11,
   parameter int AW    = $clog2(SLOTS_DEF)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

>>> rtl/core/odl_engine.sv
`timescale 1ns / 1ps
`include "ordered_dirty_list_with_batch_cursor_defines.svh"
module odl_engine
   import odl_pkg::*;
#(
   parameter int SLOTS     = SLOTS_DEF,
   parameter int MAX_BATCH = MAX_BATCH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [9:0]  req_slot,
   input  logic [63:0] req_log_pos,
   input  logic [63:0] req_fake_pos,
   input  logic [6:0]  batch_size,
   input  logic [20:0] max_batch,
   input  logic        out_free,
   output logic        beat_load,
   output beat_type    beat
);

   localparam int SW = $clog2(SLOTS);
   localparam int LW = $clog2(SLOTS + 2);
   localparam logic [LW-1:0] END_MARK  = LW'(SLOTS);
   localparam logic [LW-1:0] NONE_MARK = LW'(SLOTS + 1);
   localparam logic [SW-1:0] LAST_IDX  = SW'(SLOTS - 1);
   localparam logic [6:0]    MAX_LIM   = 7'(MAX_BATCH);

   state_type state_ff, state_in;

   logic [SW-1:0] clr_ff;
   logic [1:0]    func_ff;
   logic [LW-1:0] slot_ff;
   logic          inr_ff;
   logic [63:0]   pos_ff;
   logic [LW-1:0] n_ff, p_ff, oldtail_ff;
   logic [1:0]    status_ff;
   logic [LW-1:0] head_ff, tail_ff, cursor_ff;
   logic [20:0]   run_ff;
   logic [LW-1:0] count_ff;
   logic [LW-1:0] id_ff, start_ff;
   logic          use_rd_ff;
   logic [6:0]    i_ff, k_ff;

   // memory ports
   logic          nx_we, nx_re, pv_we, pv_re, ps_we, ps_re;
   logic [SW-1:0] nx_wa, nx_ra, pv_wa, pv_ra, ps_wa, ps_ra;
   logic [LW-1:0] nx_wd, nx_rd, pv_wd, pv_rd;
   logic [63:0]   ps_wd, ps_rd;

   odl_ram #(.DEPTH(SLOTS), .WIDTH(LW), .AW(SW)) u_next (
      .clock(clock), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd),
      .re(nx_re), .raddr(nx_ra), .rdata(nx_rd)
   );
   odl_ram #(.DEPTH(SLOTS), .WIDTH(LW), .AW(SW)) u_prev (
      .clock(clock), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd),
      .re(pv_re), .raddr(pv_ra), .rdata(pv_rd)
   );
   odl_ram #(.DEPTH(SLOTS), .WIDTH(64), .AW(SW)) u_pos (
      .clock(clock), .we(ps_we), .waddr(ps_wa), .wdata(ps_wd),
      .re(ps_re), .raddr(ps_ra), .rdata(ps_rd)
   );

   // input slot widened, range checked
   logic [WIDE_W-1:0] slot_w;
   logic [LW-1:0]     slot_lw;
   logic              slot_inr;
   assign slot_w   = WIDE_W'(req_slot);
   assign slot_lw  = slot_w[LW-1:0];
   assign slot_inr = slot_w < WIDE_W'(SLOTS);

   logic [6:0] limit;
   assign limit = (batch_size > MAX_LIM) ? MAX_LIM : batch_size;

   // walk position: straight from the link read after an advance
   logic [LW-1:0] cur_id;
   logic          cnt_go;
   logic [21:0]   run_sum;
   assign cur_id  = use_rd_ff ? nx_rd : id_ff;
   assign cnt_go  = (i_ff < limit) && (cur_id < END_MARK);
   assign run_sum = 22'(run_ff) + 22'(i_ff);

   // decision on the looked-up entry
   logic       listed, tail_v, order_bad, dec_wpos;
   logic [1:0] dec_status;
   state_type  dec_next;
   assign listed    = inr_ff && (nx_rd != NONE_MARK);
   assign tail_v    = tail_ff < END_MARK;
   assign order_bad = tail_v && (ps_rd > pos_ff);

   always_comb begin
      dec_status = ST_OK;
      dec_next   = S_RESP;
      dec_wpos   = 1'b0;
      case (func_ff)
         FN_INSERT: begin
            if (!inr_ff) dec_status = ST_NOT_LISTED;
            else if (listed) dec_status = ST_LISTED;
            else if (order_bad) dec_status = ST_ORDER;
            else begin
               dec_wpos = 1'b1;
               dec_next = S_SELF;
            end
         end
         FN_REMOVE: begin
            if (!listed) dec_status = ST_NOT_LISTED;
            else dec_next = S_UNLINK;
         end
         FN_ADJUST: begin
            if (!listed) dec_status = ST_NOT_LISTED;
            else if (nx_rd >= END_MARK) dec_wpos = 1'b1;
            else if (order_bad) dec_status = ST_ORDER;
            else begin
               dec_wpos = 1'b1;
               dec_next = S_UNLINK;
            end
         end
         default: dec_next = S_RESP;
      endcase
   end

   logic [WIDE_W-1:0] cnt_w, id_w;
   assign cnt_w = WIDE_W'(count_ff);
   assign id_w  = WIDE_W'(cur_id);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (clr_ff == LAST_IDX) state_in = S_IDLE;
         S_IDLE: begin
            if (req_valid) begin
               if (req_func == FN_BATCH)
                  state_in = (head_ff >= END_MARK) ? S_RESP : S_COUNT;
               else state_in = S_DECIDE;
            end
         end
         S_DECIDE: state_in = dec_next;
         S_UNLINK: state_in = S_SELF;
         S_SELF:   state_in = (func_ff == FN_REMOVE) ? S_RESP : S_LINK;
         S_LINK:   state_in = S_RESP;
         S_COUNT: begin
            if (!cnt_go) state_in = (i_ff == 7'd0) ? S_RESP : S_EMIT;
         end
         S_EMIT: if (out_free && (k_ff + 7'd1 == i_ff)) state_in = S_IDLE;
         S_RESP: if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // memory ports, handshake and result beat
   always_comb begin
      nx_we = 1'b0; nx_wa = '0; nx_wd = '0; nx_re = 1'b0; nx_ra = '0;
      pv_we = 1'b0; pv_wa = '0; pv_wd = '0; pv_re = 1'b0; pv_ra = '0;
      ps_we = 1'b0; ps_wa = '0; ps_wd = '0; ps_re = 1'b0; ps_ra = '0;
      req_stall = 1'b1;
      beat_load = 1'b0;
      beat      = '0;
      case (state_ff)
         S_CLEAR: begin
            nx_we = 1'b1; nx_wa = clr_ff; nx_wd = NONE_MARK;
            pv_we = 1'b1; pv_wa = clr_ff; pv_wd = NONE_MARK;
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               nx_re = 1'b1; nx_ra = slot_lw[SW-1:0];
               pv_re = 1'b1; pv_ra = slot_lw[SW-1:0];
               ps_re = 1'b1; ps_ra = tail_ff[SW-1:0];
            end
         end
         S_DECIDE: begin
            ps_we = dec_wpos; ps_wa = slot_ff[SW-1:0]; ps_wd = pos_ff;
         end
         S_UNLINK: begin
            nx_we = p_ff < END_MARK; nx_wa = p_ff[SW-1:0]; nx_wd = n_ff;
            pv_we = n_ff < END_MARK; pv_wa = n_ff[SW-1:0]; pv_wd = p_ff;
         end
         S_SELF: begin
            nx_we = 1'b1; nx_wa = slot_ff[SW-1:0];
            pv_we = 1'b1; pv_wa = slot_ff[SW-1:0];
            if (func_ff == FN_REMOVE) begin
               nx_wd = NONE_MARK;
               pv_wd = NONE_MARK;
            end else begin
               nx_wd = END_MARK;
               pv_wd = tail_ff;
            end
         end
         S_LINK: begin
            nx_we = oldtail_ff < END_MARK; nx_wa = oldtail_ff[SW-1:0];
            nx_wd = slot_ff;
         end
         S_COUNT: begin
            nx_re = cnt_go; nx_ra = cur_id[SW-1:0];
         end
         S_EMIT: begin
            if (out_free) begin
               nx_re = 1'b1; nx_ra = cur_id[SW-1:0];
               beat_load = 1'b1;
               beat.slot_out    = id_w[9:0];
               beat.slot_valid  = 1'b1;
               beat.last        = (k_ff + 7'd1 == i_ff);
               beat.batch_count = i_ff;
               beat.status      = ST_OK;
               beat.list_count  = cnt_w[10:0];
            end
         end
         S_RESP: begin
            if (out_free) begin
               beat_load = 1'b1;
               beat.last       = 1'b1;
               beat.status     = status_ff;
               beat.list_count = cnt_w[10:0];
            end
         end
         default: req_stall = 1'b1;
      endcase
   end

   // state and list registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         head_ff   <= END_MARK;
         tail_ff   <= END_MARK;
         cursor_ff <= NONE_MARK;
         run_ff    <= '0;
         count_ff  <= '0;
         use_rd_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            S_CLEAR: clr_ff <= clr_ff + SW'(1);
            S_IDLE: begin
               if (req_valid) begin
                  func_ff   <= req_func;
                  slot_ff   <= slot_lw;
                  inr_ff    <= slot_inr;
                  pos_ff    <= (req_func == FN_INSERT && req_log_pos != 64'd0) ?
                               req_log_pos : req_fake_pos;
                  status_ff <= ST_OK;
                  i_ff      <= '0;
                  use_rd_ff <= 1'b0;
                  id_ff     <= (cursor_ff == NONE_MARK) ? head_ff : cursor_ff;
                  start_ff  <= (cursor_ff == NONE_MARK) ? head_ff : cursor_ff;
               end
            end
            S_DECIDE: begin
               n_ff      <= nx_rd;
               p_ff      <= pv_rd;
               status_ff <= dec_status;
            end
            S_UNLINK: begin
               if (p_ff >= END_MARK) head_ff <= n_ff;
               if (n_ff >= END_MARK) tail_ff <= p_ff;
               if (cursor_ff == slot_ff)
                  cursor_ff <= (n_ff < END_MARK) ? n_ff :
                               ((p_ff < END_MARK) ? head_ff : n_ff);
               if (func_ff == FN_REMOVE) count_ff <= count_ff - LW'(1);
            end
            S_SELF: begin
               if (func_ff != FN_REMOVE) begin
                  oldtail_ff <= tail_ff;
                  tail_ff    <= slot_ff;
                  if (tail_ff >= END_MARK) head_ff <= slot_ff;
               end
               if (func_ff == FN_INSERT) count_ff <= count_ff + LW'(1);
            end
            S_COUNT: begin
               if (cnt_go) begin
                  i_ff      <= i_ff + 7'd1;
                  use_rd_ff <= 1'b1;
               end else begin
                  use_rd_ff <= 1'b0;
                  id_ff     <= start_ff;
                  k_ff      <= '0;
                  if (cur_id >= END_MARK || run_sum > 22'(max_batch)) begin
                     cursor_ff <= head_ff;
                     run_ff    <= '0;
                  end else begin
                     cursor_ff <= cur_id;
                     run_ff    <= run_sum[20:0];
                  end
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  k_ff      <= k_ff + 7'd1;
                  use_rd_ff <= 1'b1;
               end else begin
                  id_ff     <= cur_id;
                  use_rd_ff <= 1'b0;
               end
            end
            default: clr_ff <= clr_ff;
         endcase
      end
   end

   // list bookkeeping checks: count range always, ends and count at rest, emit bound in a batch
   `ODL_ASSERT_NOW(a_count_range, 1'b1, count_ff <= END_MARK, "entry count above slot count")
   `ODL_ASSERT_NOW(a_ends_agree, state_ff == S_IDLE, (head_ff < END_MARK) == (tail_ff < END_MARK), "head and tail disagree on empty list")
   `ODL_ASSERT_NOW(a_empty_count, state_ff == S_IDLE, (count_ff == '0) == (head_ff >= END_MARK), "entry count disagrees with head")
   `ODL_ASSERT_NEXT(a_emit_bound, state_ff == S_EMIT, k_ff <= i_ff, "batch emitted more than counted")

endmodule

>>> tb/sv/ordered_dirty_list_with_batch_cursor_tb.sv
`timescale 1ns / 1ps
module ordered_dirty_list_with_batch_cursor_tb;
   import odl_pkg::*;

   localparam int NSLOT     = 1024;
   localparam int END_LINK  = NSLOT;
   localparam int OFF_LIST  = NSLOT + 1;
   localparam int WDOG_MAX  = 20000;
   localparam int DRAIN_CYC = 160;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic        csr_index;
   logic [20:0] csr_wdata;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_func;
   logic [9:0]  req_slot;
   logic [63:0] req_log_pos;
   logic [63:0] req_fake_pos;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [9:0]  rsp_slot_out;
   logic        rsp_slot_valid;
   logic        rsp_last;
   logic [6:0]  rsp_batch_count;
   logic [1:0]  rsp_status;
   logic [10:0] rsp_list_count;

   ordered_dirty_list_with_batch_cursor i_dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_slot(req_slot), .req_log_pos(req_log_pos), .req_fake_pos(req_fake_pos),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_slot_out(rsp_slot_out),
      .rsp_slot_valid(rsp_slot_valid), .rsp_last(rsp_last),
      .rsp_batch_count(rsp_batch_count), .rsp_status(rsp_status),
      .rsp_list_count(rsp_list_count)
   );

   // shadow list state
   int          next_of [NSLOT];
   int          prev_of [NSLOT];
   logic [63:0] age_of  [NSLOT];
   int          head_at, tail_at, cursor_at, batch_run, listed_n;
   int          batch_lim_reg, batch_cap_reg;
   beat_type    pending_beats[$];

   int  errors, items_sent, beats_seen, idle_cycles;
   int  gap_pct, stall_pct;
   logic [63:0] pos_clock;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // receiver back-pressure
   always @(posedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   task automatic report(string what);
      errors++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   // result checker
   always @(posedge clock) begin
      beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_seen++;
         if (pending_beats.size() == 0) begin
            report("result beat with nothing expected");
         end else begin
            want = pending_beats.pop_front();
            if (rsp_slot_out !== want.slot_out)
               report($sformatf("slot_out %0d want %0d", rsp_slot_out, want.slot_out));
            if (rsp_slot_valid !== want.slot_valid)
               report($sformatf("slot_valid %0b want %0b", rsp_slot_valid, want.slot_valid));
            if (rsp_last !== want.last)
               report($sformatf("last %0b want %0b", rsp_last, want.last));
            if (rsp_batch_count !== want.batch_count)
               report($sformatf("batch_count %0d want %0d", rsp_batch_count,
                                want.batch_count));
            if (rsp_status !== want.status)
               report($sformatf("status %0d want %0d", rsp_status, want.status));
            if (rsp_list_count !== want.list_count)
               report($sformatf("list_count %0d want %0d", rsp_list_count,
                                want.list_count));
         end
      end
   end

   // watchdog on beats in either direction
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WDOG_MAX) begin
         $display("ordered_dirty_list_with_batch_cursor test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic void push_beat(int s, bit v, bit lst, int n, status_type st);
      beat_type b;
      b.slot_out    = s[9:0];
      b.slot_valid  = v;
      b.last        = lst;
      b.batch_count = n[6:0];
      b.status      = st;
      b.list_count  = listed_n[10:0];
      pending_beats.push_back(b);
   endfunction

   function automatic void unlink(int s);
      int p, n;
      p = prev_of[s];
      n = next_of[s];
      if (p < NSLOT) next_of[p] = n; else head_at = n;
      if (n < NSLOT) prev_of[n] = p; else tail_at = p;
      if (cursor_at == s) cursor_at = (n < NSLOT) ? n : head_at;
      next_of[s] = OFF_LIST;
      prev_of[s] = OFF_LIST;
   endfunction

   function automatic void append(int s);
      next_of[s] = END_LINK;
      if (tail_at >= NSLOT) begin
         prev_of[s] = END_LINK;
         head_at = s;
      end else begin
         prev_of[s] = tail_at;
         next_of[tail_at] = s;
      end
      tail_at = s;
   endfunction

   // expected beats for one accepted request
   function automatic void predict(func_type f, int s, logic [63:0] lp, logic [63:0] fp);
      int ids[$];
      int id, lim;
      status_type st;
      logic [63:0] p;
      st = ST_OK;
      if (f == FN_BATCH) begin
         lim = (batch_lim_reg > 64) ? 64 : batch_lim_reg;
         if (head_at >= NSLOT) begin
            push_beat(0, 0, 1, 0, ST_OK);
            return;
         end
         if (cursor_at == OFF_LIST) cursor_at = head_at;
         id = cursor_at;
         while (ids.size() < lim && id < NSLOT) begin
            ids.push_back(id);
            id = next_of[id];
         end
         if (id >= NSLOT || batch_run + ids.size() > batch_cap_reg) begin
            cursor_at = head_at;
            batch_run = 0;
         end else begin
            cursor_at = id;
            batch_run += ids.size();
         end
         if (ids.size() == 0) push_beat(0, 0, 1, 0, ST_OK);
         foreach (ids[k]) push_beat(ids[k], 1, k == ids.size() - 1, ids.size(), ST_OK);
         return;
      end
      case (f)
         FN_INSERT: begin
            p = (lp != 0) ? lp : fp;
            if (next_of[s] != OFF_LIST) st = ST_LISTED;
            else if (tail_at < NSLOT && age_of[tail_at] > p) st = ST_ORDER;
            else begin
               age_of[s] = p;
               append(s);
               listed_n++;
            end
         end
         FN_REMOVE: begin
            if (next_of[s] == OFF_LIST) st = ST_NOT_LISTED;
            else begin
               age_of[s] = '0;
               unlink(s);
               listed_n--;
            end
         end
         default: begin
            if (next_of[s] == OFF_LIST) st = ST_NOT_LISTED;
            else if (next_of[s] >= NSLOT) age_of[s] = fp;
            else if (tail_at < NSLOT && age_of[tail_at] > fp) st = ST_ORDER;
            else begin
               age_of[s] = fp;
               unlink(s);
               append(s);
            end
         end
      endcase
      push_beat(0, 0, 1, 0, st);
   endfunction

   // one request beat, with an optional idle gap ahead of it
   task automatic send_item(func_type f, int s, logic [63:0] lp, logic [63:0] fp);
      int gap;
      if ($urandom_range(99) < gap_pct) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_func     <= f;
      req_slot     <= s[9:0];
      req_log_pos  <= lp;
      req_fake_pos <= fp;
      do @(posedge clock); while (req_stall);
      predict(f, s, lp, fp);
      items_sent++;
   endtask

   // wait for all results, then let the engine settle
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, int val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[20:0];
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == CSR_BATCH_SIZE) batch_lim_reg = val & 'h7F;
      else batch_cap_reg = val & 'h1FFFFF;
   endtask

   task automatic set_regs(int bs, int mb);
      drain();
      write_reg(CSR_BATCH_SIZE, bs);
      write_reg(CSR_MAX_BATCH, mb);
   endtask

   // empty list reads, inserts, and error status on unlisted, already listed and out-of-order slots
   task automatic test_errors();
      send_item(FN_BATCH, 0, 0, 0);
      send_item(FN_REMOVE, 5, 0, 0);
      send_item(FN_ADJUST, 1023, 0, 64'd10);
      send_item(FN_INSERT, 0, 0, 64'd100);
      send_item(FN_INSERT, 0, 64'd200, 64'd0);
      send_item(FN_INSERT, 1023, 64'd50, 64'd0);
      send_item(FN_INSERT, 1023, 64'd0, 64'd100);
   endtask

   // position order, tail adjust and cursor following removals
   task automatic test_order_and_cursor();
      send_item(FN_INSERT, 7, 64'd100, 0);
      send_item(FN_INSERT, 8, 64'hFFFF_FFFF_FFFF_FFFF, 0);
      send_item(FN_ADJUST, 8, 0, 64'd120);
      send_item(FN_ADJUST, 0, 0, 64'd110);
      send_item(FN_ADJUST, 7, 0, 64'd130);
      send_item(FN_ADJUST, 1023, 0, 64'd90);
      send_item(FN_BATCH, 0, 0, 0);
      send_item(FN_REMOVE, 8, 0, 0);
      send_item(FN_REMOVE, 7, 0, 0);
      send_item(FN_BATCH, 0, 0, 0);
   endtask

   // register extremes: zero, one and oversize batch sizes, tight and wide caps
   task automatic test_reg_extremes();
      set_regs(0, 1);
      send_item(FN_BATCH, 0, 0, 0);
      set_regs(1, 1);
      send_item(FN_BATCH, 0, 0, 0);
      send_item(FN_BATCH, 0, 0, 0);
      set_regs(127, 2097151);
      send_item(FN_BATCH, 0, 0, 0);
      send_item(FN_BATCH, 0, 0, 0);
   endtask

   // mostly ordered traffic over a small slot pool, some noise
   task automatic test_random(int n);
      func_type f;
      int s, r;
      logic [63:0] lp, fp;
      repeat (n) begin
         r = $urandom_range(99);
         f = (r < 35) ? FN_INSERT : (r < 55) ? FN_REMOVE : (r < 70) ? FN_ADJUST : FN_BATCH;
         s = ($urandom_range(99) < 85) ? $urandom_range(40) : $urandom_range(1023);
         pos_clock += $urandom_range(1, 50);
         fp = pos_clock + $urandom_range(20);
         lp = ($urandom_range(3) == 0) ? 64'd0 : pos_clock;
         if ($urandom_range(99) < 6) lp = {$urandom, $urandom};
         if ($urandom_range(99) < 6) fp = {$urandom, $urandom};
         send_item(f, s, lp, fp);
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_BATCH_SIZE;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_func = FN_INSERT;
      req_slot = '0;
      req_log_pos = '0;
      req_fake_pos = '0;
      rsp_stall = 1'b0;
      errors = 0;
      items_sent = 0;
      beats_seen = 0;
      idle_cycles = 0;
      gap_pct = 0;
      stall_pct = 0;
      pos_clock = 64'd1000;
      foreach (next_of[i]) begin
         next_of[i] = OFF_LIST;
         prev_of[i] = OFF_LIST;
         age_of[i]  = '0;
      end
      head_at = END_LINK;
      tail_at = END_LINK;
      cursor_at = OFF_LIST;
      batch_run = 0;
      listed_n = 0;
      batch_lim_reg = 16;
      batch_cap_reg = 1024;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_errors();
      test_order_and_cursor();
      test_random(20);
      test_reg_extremes();

      // random phases with different idle and stall mixes
      set_regs(16, 1024);
      test_random(42);
      set_regs(64, 1048576);
      gap_pct = 50;
      test_random(42);
      set_regs(5, 20);
      gap_pct = 0;
      stall_pct = 50;
      test_random(42);
      set_regs(3, 1);
      gap_pct = 32;
      stall_pct = 32;
      test_random(42);
      drain();

      $display("covered %0d requests and %0d result beats", items_sent, beats_seen);
      $display("inserts, removes, adjusts, batch reads under four idle/stall mixes");
      if (errors == 0 && pending_beats.size() == 0) begin
         $display("ordered_dirty_list_with_batch_cursor test passed");
      end else begin
         $display("ordered_dirty_list_with_batch_cursor test failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/odl_pkg.sv
rtl/core/odl_ram.sv
rtl/core/odl_engine.sv
rtl/core/ordered_dirty_list_with_batch_cursor.sv
tb/sv/ordered_dirty_list_with_batch_cursor_tb.sv
